>>> sv/pwto_pkg.sv
`default_nettype none

package pwto_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int VOICES_DEF      = 16;

    localparam int CFG_IW = 4;
    localparam int CFG_DW = 23;

    // register map
    localparam logic [CFG_IW-1:0] REG_BASE_PITCH    = 4'd0;
    localparam logic [CFG_IW-1:0] REG_PHASE_KNOB    = 4'd1;
    localparam logic [CFG_IW-1:0] REG_VOLUME_KNOB   = 4'd2;
    localparam logic [CFG_IW-1:0] REG_FM_ATTN       = 4'd3;
    localparam logic [CFG_IW-1:0] REG_PM_ATTN       = 4'd4;
    localparam logic [CFG_IW-1:0] REG_VM_ATTN       = 4'd5;
    localparam logic [CFG_IW-1:0] REG_MODE_BITS     = 4'd6;
    localparam logic [CFG_IW-1:0] REG_SAMPLE_PERIOD = 4'd7;

    // mode bit positions
    localparam int MODE_LIMITED = 0;
    localparam int MODE_FM      = 1;
    localparam int MODE_PM      = 2;
    localparam int MODE_VM      = 3;

    localparam logic [22:0] BASE_PITCH_RST    = 23'd66980;
    localparam logic [16:0] VOLUME_RST        = 17'd32768;
    localparam logic [19:0] SAMPLE_PERIOD_RST = 20'd97392;

    // frequency clamp, Q.8 Hz
    localparam logic [22:0] F_MIN = 23'd2560;
    localparam logic [22:0] F_MAX = 23'd5120000;

    // 0.1 in Q16
    localparam logic signed [15:0] MOD_GAIN = 16'sd6554;

    localparam logic [31:0] EXP_ONE = 32'h4000_0000;

    typedef struct packed {
        logic              action;
        logic [3:0]        voice;
        logic signed [15:0] pitch_volts;
        logic signed [15:0] fm_volts;
        logic signed [15:0] pm_volts;
        logic signed [15:0] vm_volts;
        logic              table_select;
        logic [9:0]        table_index;
        logic signed [15:0] table_value;
    } in_t;

    typedef struct packed {
        logic [3:0]         out_voice;
        logic signed [15:0] audio_out;
    } out_t;

    typedef struct packed {
        logic [22:0]        base_pitch_hz;
        logic [15:0]        phase_knob;
        logic [16:0]        volume_knob;
        logic signed [15:0] fm_attn;
        logic signed [15:0] pm_attn;
        logic signed [15:0] vm_attn;
        logic [3:0]         mode_bits;
        logic [19:0]        sample_period;
    } cfg_t;

    // round(2^(2^(b-11)) * 65536)
    function automatic logic [16:0] exp_step(input logic [3:0] b);
        logic [16:0] k;
        case (b)
            4'd0:    k = 17'd65558;
            4'd1:    k = 17'd65580;
            4'd2:    k = 17'd65625;
            4'd3:    k = 17'd65714;
            4'd4:    k = 17'd65892;
            4'd5:    k = 17'd66250;
            4'd6:    k = 17'd66971;
            4'd7:    k = 17'd68438;
            4'd8:    k = 17'd71468;
            4'd9:    k = 17'd77936;
            4'd10:   k = 17'd92682;
            default: k = 17'd65536;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

>>> sv/poly_wavetable_triangle_oscillator.sv
`default_nettype none

// Channel | Direction | Handshake            | Payload
// --------+-----------+----------------------+-------------------------------
// in      | input     | in_valid / in_ready  | in_item  (pwto_pkg::in_t)
// out     | output    | out_valid / out_ready| out_item (pwto_pkg::out_t)
// cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A load transaction writes its table word in the cycle it is taken.
// A sample transaction waits in the exp2 state while the 11 fraction bits are
// processed one per step on a shared multiplier and the done flag is raised,
// then passes through one state each for pitch scaling, FM product, clamp, phase
// step, phase RAM update, table index, table RAM read, volume product and
// rounding; the next transaction is taken once rounding has loaded the result.
// Reset loads the config registers with their reset values and marks all
// voice phases as zero via per-voice valid bits. A stalled output holds the
// finished sample in its register; the next transaction is taken while it
// waits, and only the final rounding step stalls if the register is still full.

module poly_wavetable_triangle_oscillator #(
    parameter int TABLE_DEPTH = pwto_pkg::TABLE_DEPTH_DEF,
    parameter int VOICES      = pwto_pkg::VOICES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire pwto_pkg::in_t               in_item,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output pwto_pkg::out_t                   out_item,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [pwto_pkg::CFG_IW-1:0] cfg_index,
    input  wire logic [pwto_pkg::CFG_DW-1:0] cfg_data
);
    import pwto_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EXP   = 4'd1;
    localparam logic [3:0] S_FREQ  = 4'd2;
    localparam logic [3:0] S_FM    = 4'd3;
    localparam logic [3:0] S_CLAMP = 4'd4;
    localparam logic [3:0] S_STEP  = 4'd5;
    localparam logic [3:0] S_PHASE = 4'd6;
    localparam logic [3:0] S_ADDR  = 4'd7;
    localparam logic [3:0] S_READ  = 4'd8;
    localparam logic [3:0] S_MUL   = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;

    cfg_t cfg;

    pwto_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    logic [3:0] state_reg, state_next;
    logic       in_take;
    logic       sample_take;
    logic       load_take;

    assign in_ready    = (state_reg == S_IDLE);
    assign in_take     = in_valid && in_ready;
    assign load_take   = in_take && in_item.action;
    assign sample_take = in_take && !in_item.action &&
                         (5'(in_item.voice) < 5'(VOICES));

    // ---------------------------------------------------------------
    // Captured sample payload
    // ---------------------------------------------------------------
    logic [3:0]         voice_reg;
    logic [4:0]         oct_reg;     // octave + 16
    logic signed [15:0] fm_reg;
    logic signed [15:0] pm_reg;
    logic signed [15:0] vm_reg;

    always_ff @(posedge clk)
    begin
        if (sample_take)
        begin
            voice_reg <= in_item.voice;
            oct_reg   <= {~in_item.pitch_volts[15], in_item.pitch_volts[14:11]};
            fm_reg    <= in_item.fm_volts;
            pm_reg    <= in_item.pm_volts;
            vm_reg    <= in_item.vm_volts;
        end
    end

    // Modulation products run freely off the captured payload; they settle
    // long before the exp2 unit finishes.
    logic signed [31:0] fa_reg;
    logic signed [31:0] pa_reg;
    logic signed [31:0] va_reg;
    logic signed [45:0] pa6_reg;
    logic signed [45:0] va6_reg;
    logic signed [45:0] pa6_shr;
    logic signed [45:0] va6_shr;
    logic signed [18:0] vol_reg;
    logic signed [18:0] vol_next;
    logic [31:0]        pshift;

    assign pa6_shr = pa6_reg >>> 10;
    assign va6_shr = va6_reg >>> 26;

    assign vol_next = $signed({2'b00, cfg.volume_knob}) +
                      (cfg.mode_bits[MODE_VM] ? va6_shr[18:0] : 19'sd0);
    assign pshift   = {cfg.phase_knob, 16'h0000} +
                      (cfg.mode_bits[MODE_PM] ? pa6_shr[31:0] : 32'd0);

    always_ff @(posedge clk)
    begin
        fa_reg  <= fm_reg * cfg.fm_attn;
        pa_reg  <= pm_reg * cfg.pm_attn;
        va_reg  <= vm_reg * cfg.vm_attn;
        pa6_reg <= pa_reg * MOD_GAIN;
        va6_reg <= va_reg * MOD_GAIN;
        vol_reg <= vol_next;
    end

    // ---------------------------------------------------------------
    // exp2 of the pitch fraction
    // ---------------------------------------------------------------
    logic        exp_done;
    logic [31:0] exp_m;

    pwto_exp u_exp (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sample_take),
        .frac  (in_item.pitch_volts[10:0]),
        .done  (exp_done),
        .mant  (exp_m)
    );

    // ---------------------------------------------------------------
    // Frequency: base * 2^pitch, FM, clamp
    // ---------------------------------------------------------------
    logic [54:0]        fprod;
    logic [5:0]         fsh;
    logic [54:0]        fshd;
    logic [31:0]        f_reg;
    logic signed [63:0] fmp_reg;
    logic signed [63:0] fmp_shr;
    logic signed [63:0] fsum;
    logic [22:0]        fc_reg;
    logic [22:0]        fc_next;
    logic [42:0]        step_prod;
    logic [31:0]        step_reg;

    assign fprod = 55'(cfg.base_pitch_hz) * 55'(exp_m);
    assign fsh   = 6'd46 - {1'b0, oct_reg};   // 30 - octave
    assign fshd  = fprod >> fsh;

    assign fmp_shr = fmp_reg >>> 27;
    assign fsum    = $signed({32'd0, f_reg}) +
                     (cfg.mode_bits[MODE_FM] ? fmp_shr : 64'sd0);

    always_comb
    begin
        if (fsum < $signed({41'd0, F_MIN}))
        begin
            fc_next = F_MIN;
        end
        else if (fsum > $signed({41'd0, F_MAX}))
        begin
            fc_next = F_MAX;
        end
        else
        begin
            fc_next = fsum[22:0];
        end
    end

    assign step_prod = 43'(fc_reg) * 43'(cfg.sample_period);

    always_ff @(posedge clk)
    begin
        if (state_reg == S_FREQ)
        begin
            f_reg <= (|fshd[54:32]) ? 32'hFFFF_FFFF : fshd[31:0];
        end
        if (state_reg == S_FM)
        begin
            fmp_reg <= $signed({1'b0, f_reg}) * fa_reg;
        end
        if (state_reg == S_CLAMP)
        begin
            fc_reg <= fc_next;
        end
        if (state_reg == S_STEP)
        begin
            step_reg <= step_prod[39:8];
        end
    end

    // ---------------------------------------------------------------
    // Voice phase RAM: read-modify-write, one item at a time so the
    // next read always follows the write-back.
    // ---------------------------------------------------------------
    logic [31:0]     ph_rd;
    logic [31:0]     ph_cur;
    logic [31:0]     ph_new;
    logic [31:0]     ph_new_reg;
    logic            ph_we;
    logic [VOICES-1:0] ph_valid_reg;
    logic [VW-1:0]   voice_addr;

    assign voice_addr = VW'(voice_reg);
    assign ph_we      = (state_reg == S_PHASE);
    assign ph_cur     = ph_valid_reg[voice_addr] ? ph_rd : 32'd0;
    assign ph_new     = ph_cur + step_reg;

    pwto_ram #(
        .WIDTH (32),
        .DEPTH (VOICES),
        .AW    (VW)
    ) u_phase_ram (
        .clk   (clk),
        .we    (ph_we),
        .waddr (voice_addr),
        .wdata (ph_new),
        .raddr (voice_addr),
        .rdata (ph_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_valid_reg <= '0;
        end
        else if (ph_we)
        begin
            ph_valid_reg[voice_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ph_we)
        begin
            ph_new_reg <= ph_new;
        end
    end

    // ---------------------------------------------------------------
    // Wave tables
    // ---------------------------------------------------------------
    logic [31:0]       total;
    logic [32+AW-1:0]  idx_prod;
    logic [AW-1:0]     idx_reg;
    logic              tbl_we;
    logic [AW-1:0]     tbl_waddr;
    logic [15:0]       plain_rd;
    logic [15:0]       limited_rd;
    logic signed [15:0] word;

    assign total    = ph_new_reg + pshift;
    assign idx_prod = (32+AW)'(total) * (32+AW)'(TABLE_DEPTH);

    assign tbl_we    = load_take && (32'(in_item.table_index) < 32'(TABLE_DEPTH));
    assign tbl_waddr = AW'(in_item.table_index);

    always_ff @(posedge clk)
    begin
        if (state_reg == S_ADDR)
        begin
            idx_reg <= idx_prod[32+AW-1:32];
        end
    end

    pwto_ram #(
        .WIDTH (16),
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_plain_ram (
        .clk   (clk),
        .we    (tbl_we && !in_item.table_select),
        .waddr (tbl_waddr),
        .wdata (in_item.table_value),
        .raddr (idx_reg),
        .rdata (plain_rd)
    );

    pwto_ram #(
        .WIDTH (16),
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_limited_ram (
        .clk   (clk),
        .we    (tbl_we && in_item.table_select),
        .waddr (tbl_waddr),
        .wdata (in_item.table_value),
        .raddr (idx_reg),
        .rdata (limited_rd)
    );

    assign word = cfg.mode_bits[MODE_LIMITED] ? $signed(limited_rd) : $signed(plain_rd);

    // ---------------------------------------------------------------
    // Volume, rounding, saturation, output register
    // ---------------------------------------------------------------
    logic signed [34:0] acc_reg;
    logic signed [34:0] rnd;
    logic signed [15:0] sat;
    logic               out_load;
    logic               out_valid_reg;
    out_t               out_item_reg;

    assign rnd = (acc_reg + 35'sd65536) >>> 17;

    always_comb
    begin
        if (rnd > 35'sd32767)
        begin
            sat = 16'sh7FFF;
        end
        else if (rnd < -35'sd32768)
        begin
            sat = 16'sh8000;
        end
        else
        begin
            sat = rnd[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_MUL)
        begin
            acc_reg <= word * vol_reg;
        end
    end

    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_item_reg.out_voice <= voice_reg;
            out_item_reg.audio_out <= sat;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (sample_take)
                begin
                    state_next = S_EXP;
                end
            end
            S_EXP:
            begin
                if (exp_done)
                begin
                    state_next = S_FREQ;
                end
            end
            S_FREQ:  state_next = S_FM;
            S_FM:    state_next = S_CLAMP;
            S_CLAMP: state_next = S_STEP;
            S_STEP:  state_next = S_PHASE;
            S_PHASE: state_next = S_ADDR;
            S_ADDR:  state_next = S_READ;
            S_READ:  state_next = S_MUL;
            S_MUL:   state_next = S_OUT;
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/pwto_ram.sv
`default_nettype none

module pwto_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> sv/pwto_exp.sv
`default_nettype none

module pwto_exp (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [10:0] frac,
    output logic             done,
    output logic [31:0]      mant
);
    import pwto_pkg::*;

    // one fraction bit per cycle, MSB first; mant is Q2.30
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [3:0]  bit_reg, bit_next;
    logic [10:0] frac_reg, frac_next;
    logic [31:0] m_reg, m_next;
    logic [48:0] prod;

    assign prod = 49'(m_reg) * 49'(exp_step(bit_reg));

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        bit_next  = bit_reg;
        frac_next = frac_reg;
        m_next    = m_reg;
        if (start)
        begin
            busy_next = 1'b1;
            bit_next  = 4'd10;
            frac_next = frac;
            m_next    = EXP_ONE;
        end
        else if (busy_reg)
        begin
            if (frac_reg[bit_reg])
            begin
                m_next = 32'((prod + 49'd32768) >> 16);
            end
            if (bit_reg == 4'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                bit_next = bit_reg - 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            bit_reg  <= 4'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            bit_reg  <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frac_reg <= frac_next;
        m_reg    <= m_next;
    end

    assign done = done_reg;
    assign mant = m_reg;

endmodule

`default_nettype wire

>>> sv/pwto_cfg.sv
`default_nettype none

module pwto_cfg (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [pwto_pkg::CFG_IW-1:0] cfg_index,
    input  wire logic [pwto_pkg::CFG_DW-1:0] cfg_data,
    output pwto_pkg::cfg_t                   cfg
);
    import pwto_pkg::*;

    cfg_t cfg_reg, cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_BASE_PITCH:    cfg_next.base_pitch_hz = cfg_data[22:0];
                REG_PHASE_KNOB:    cfg_next.phase_knob    = cfg_data[15:0];
                REG_VOLUME_KNOB:   cfg_next.volume_knob   = cfg_data[16:0];
                REG_FM_ATTN:       cfg_next.fm_attn       = cfg_data[15:0];
                REG_PM_ATTN:       cfg_next.pm_attn       = cfg_data[15:0];
                REG_VM_ATTN:       cfg_next.vm_attn       = cfg_data[15:0];
                REG_MODE_BITS:     cfg_next.mode_bits     = cfg_data[3:0];
                REG_SAMPLE_PERIOD: cfg_next.sample_period = cfg_data[19:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_pitch_hz <= BASE_PITCH_RST;
            cfg_reg.phase_knob    <= 16'd0;
            cfg_reg.volume_knob   <= VOLUME_RST;
            cfg_reg.fm_attn       <= 16'sd0;
            cfg_reg.pm_attn       <= 16'sd0;
            cfg_reg.vm_attn       <= 16'sd0;
            cfg_reg.mode_bits     <= 4'd0;
            cfg_reg.sample_period <= SAMPLE_PERIOD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

endmodule

`default_nettype wire
